@@ hdl/dpd_pkg.sv @@
`timescale 1ns / 1ps
package dpd_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);

    localparam logic [7:0] START_BYTE_RST      = 8'd64;
    localparam logic [7:0] FIRST_END_BYTE_RST  = 8'd13;
    localparam logic [7:0] SECOND_END_BYTE_RST = 8'd10;

    typedef enum logic [1:0] {
        CFG_START_BYTE      = 2'd0,
        CFG_FIRST_END_BYTE  = 2'd1,
        CFG_SECOND_END_BYTE = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_AWAIT   = 2'd2
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_ctl_state;

    typedef struct packed {
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        overrun;
        logic [31:0] now_ticks;
    } t_in_item;

    typedef struct packed {
        logic        out_is_data;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [5:0]  out_length;
        logic [31:0] out_time;
        logic [31:0] error_total;
    } t_out_item;

endpackage

@@ hdl/dpd_ram.sv @@
`timescale 1ns / 1ps
module dpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/delimited_packet_deframer_top.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
// out      output     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item that completes no packet gives one status item.
// A completed packet of N bytes is read from the packet RAM one byte a cycle
// while the output is not stalled; the single RAM read port sets that rate.
// Reset is synchronous: phase hunt, fill count and error tally zero, registers
// at defaults. RAM contents are not cleared. A stalled output holds the
// readout; input is taken again only once the last byte is loaded.
module delimited_packet_deframer_top
    import dpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]        r_start_byte;
    logic [7:0]        r_first_end;
    logic [7:0]        r_second_end;
    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_fill, n_fill;
    logic [31:0]       r_tally, n_tally;
    t_ctl_state        r_state, n_state;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [31:0]       r_time, n_time;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic              emit;
    logic              mem_we;
    logic [1:0]        err_inc;
    logic [7:0]        rd_data;
    logic              is_last;

    dpd_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_fill),
        .i_wdata(i_in_item.rx_byte),
        .i_raddr(n_rd_idx),
        .o_rdata(rd_data)
    );

    // outputs
    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        o_in_ready  = (r_state == ST_IDLE) && out_free;
        in_acc      = i_in_valid && o_in_ready;
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_out_item  = r_out;
        is_last     = (ADDR_W'(r_rd_idx + 1'b1) == r_fill);
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_tally     = r_tally;
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_time      = r_time;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        emit        = 1'b0;
        mem_we      = 1'b0;
        err_inc     = 2'd0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.rx_valid) begin
                        case (r_phase)
                            PH_HUNT: begin
                                if (i_in_item.rx_byte == r_start_byte) begin
                                    n_phase = PH_PAYLOAD;
                                    n_fill  = '0;
                                end
                            end
                            PH_PAYLOAD: begin
                                if (i_in_item.rx_byte == r_first_end) begin
                                    n_phase = PH_AWAIT;
                                end else if (r_fill < ADDR_W'(BUFFER_BYTES - 1)) begin
                                    mem_we = 1'b1;
                                    n_fill = ADDR_W'(r_fill + 1'b1);
                                end else begin
                                    err_inc = 2'd1;
                                    n_phase = PH_HUNT;
                                end
                            end
                            PH_AWAIT: begin
                                if (i_in_item.rx_byte == r_second_end) begin
                                    if (r_fill != '0) begin
                                        emit = 1'b1;
                                    end else begin
                                        err_inc = 2'd1;
                                    end
                                end else begin
                                    err_inc = 2'd1;
                                end
                                n_phase = PH_HUNT;
                            end
                            default: begin
                                n_phase = PH_HUNT;
                            end
                        endcase
                    end
                    if (i_in_item.overrun) begin
                        err_inc = err_inc + 2'd1;
                        n_phase = PH_HUNT;
                    end
                    n_tally = r_tally + 32'(err_inc);
                    if (emit) begin
                        n_state  = ST_SEND;
                        n_rd_idx = '0;
                        n_time   = i_in_item.now_ticks;
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.out_is_data = 1'b0;
                        n_out.out_byte    = 8'd0;
                        n_out.out_last    = 1'b1;
                        n_out.out_length  = 6'd0;
                        n_out.out_time    = 32'd0;
                        n_out.error_total = n_tally;
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_is_data = 1'b1;
                    n_out.out_byte    = rd_data;
                    n_out.out_last    = is_last;
                    n_out.out_length  = 6'(r_fill);
                    n_out.out_time    = r_time;
                    n_out.error_total = r_tally;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = ADDR_W'(r_rd_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_first_end  <= FIRST_END_BYTE_RST;
            r_second_end <= SECOND_END_BYTE_RST;
            r_phase      <= PH_HUNT;
            r_fill       <= '0;
            r_tally      <= '0;
            r_state      <= ST_IDLE;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_BYTE:      r_start_byte <= i_cfg_data;
                    CFG_FIRST_END_BYTE:  r_first_end  <= i_cfg_data;
                    CFG_SECOND_END_BYTE: r_second_end <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_tally     <= n_tally;
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_out  <= n_out;
    end

endmodule

@@ test/tb_delimited_packet_deframer_top.sv @@
`timescale 1ns / 1ps
module tb_delimited_packet_deframer_top;
    import dpd_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 70;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    // predictor state
    logic [7:0]  start_r, first_end_r, second_end_r;
    t_phase      cur_phase;
    int          fill;
    logic [7:0]  pkt_mem [BUFFER_BYTES];
    logic [31:0] tally;
    t_out_item   due_outputs [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ovr_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;

    always #5 i_clk = ~i_clk;

    delimited_packet_deframer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    task automatic deframe_step(input t_in_item it);
        int emit_len;
        t_out_item r;
        emit_len = 0;
        if (it.rx_valid) begin
            case (cur_phase)
                PH_HUNT: begin
                    if (it.rx_byte == start_r) begin
                        cur_phase = PH_PAYLOAD;
                        fill = 0;
                    end
                end
                PH_PAYLOAD: begin
                    if (it.rx_byte == first_end_r) begin
                        cur_phase = PH_AWAIT;
                    end else if (fill < BUFFER_BYTES - 1) begin
                        pkt_mem[fill[ADDR_W-1:0]] = it.rx_byte;
                        fill++;
                    end else begin
                        tally++;
                        cur_phase = PH_HUNT;
                    end
                end
                PH_AWAIT: begin
                    if (it.rx_byte == second_end_r) begin
                        if (fill > 0) emit_len = fill;
                        else tally++;
                    end else begin
                        tally++;
                    end
                    cur_phase = PH_HUNT;
                end
                default: cur_phase = PH_HUNT;
            endcase
        end
        if (it.overrun) begin
            tally++;
            cur_phase = PH_HUNT;
        end
        if (emit_len == 0) begin
            r = '0;
            r.out_last = 1'b1;
            r.error_total = tally;
            due_outputs.push_back(r);
        end else begin
            for (int k = 0; k < emit_len; k++) begin
                r.out_is_data = 1'b1;
                r.out_byte    = pkt_mem[k[ADDR_W-1:0]];
                r.out_last    = (k == emit_len - 1);
                r.out_length  = emit_len[5:0];
                r.out_time    = it.now_ticks;
                r.error_total = tally;
                due_outputs.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (due_outputs.size() == 0) begin
                errors++;
                $display("%0t: output item with none expected, actual %h",
                         $time, o_out_item);
            end else begin
                e = due_outputs.pop_front();
                check_field("out_is_data", 32'(e.out_is_data),
                            32'(o_out_item.out_is_data));
                check_field("out_byte", 32'(e.out_byte), 32'(o_out_item.out_byte));
                check_field("out_last", 32'(e.out_last), 32'(o_out_item.out_last));
                check_field("out_length", 32'(e.out_length),
                            32'(o_out_item.out_length));
                check_field("out_time", e.out_time, o_out_item.out_time);
                check_field("error_total", e.error_total, o_out_item.error_total);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready = 1'b0;
        end else begin
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("delimited_packet_deframer_top regression: fail");
        $finish;
    end

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_step(it);
        items_sent++;
    endtask

    task automatic send_raw(input logic vld, input logic [7:0] data_b, input logic ovr);
        t_in_item it;
        it.rx_valid  = vld;
        it.rx_byte   = data_b;
        it.overrun   = ovr;
        it.now_ticks = $urandom;
        send_item(it);
    endtask

    task automatic send_rx(input logic [7:0] data_b);
        send_raw(1'b1, data_b, $urandom_range(99) < ovr_pct);
    endtask

    task automatic send_packet(input int len, input logic bad_tail);
        logic [7:0] b;
        send_rx(start_r);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (b == first_end_r) b = ~b;
            send_rx(b);
        end
        send_rx(first_end_r);
        send_rx(bad_tail ? ~second_end_r : second_end_r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_drained();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_BYTE:      start_r = val;
            CFG_FIRST_END_BYTE:  first_end_r = val;
            CFG_SECOND_END_BYTE: second_end_r = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_framing(input logic [7:0] s, f, l);
        write_reg(CFG_START_BYTE, s);
        write_reg(CFG_FIRST_END_BYTE, f);
        write_reg(CFG_SECOND_END_BYTE, l);
    endtask

    task automatic do_reset();
        start_r      = START_BYTE_RST;
        first_end_r  = FIRST_END_BYTE_RST;
        second_end_r = SECOND_END_BYTE_RST;
        cur_phase    = PH_HUNT;
        fill         = 0;
        tally        = '0;
        i_rst_n      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    task automatic test_directed();
        t_in_item it;
        send_raw(1'b0, 8'hFF, 1'b0);                 // no byte
        send_raw(1'b1, 8'h55, 1'b0);                 // noise while hunting
        send_rx(start_r);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(start_r);                            // start byte inside payload
        send_rx(first_end_r);
        it = '{rx_valid: 1'b1, rx_byte: second_end_r, overrun: 1'b0, now_ticks: '1};
        send_item(it);
        send_rx(start_r);
        send_rx(8'h01);
        send_rx(first_end_r);
        it = '{rx_valid: 1'b1, rx_byte: second_end_r, overrun: 1'b0, now_ticks: '0};
        send_item(it);
        send_rx(start_r);                            // empty payload
        send_rx(first_end_r);
        send_rx(second_end_r);
        send_rx(start_r);                            // wrong byte after first end
        send_rx(8'h42);
        send_rx(first_end_r);
        send_rx(start_r);                            // not taken as new start
        send_rx(8'h11);
        send_raw(1'b1, 8'h22, 1'b1);                 // overrun in payload
        send_rx(start_r);
        send_rx(8'h80);
        send_rx(first_end_r);
        send_raw(1'b1, second_end_r, 1'b1);          // overrun on completing byte
        send_raw(1'b0, 8'h00, 1'b1);                 // overrun with no byte
    endtask

    task automatic test_max_and_overflow();
        send_packet(BUFFER_BYTES - 1, 1'b0);
        send_rx(start_r);
        for (int i = 0; i < BUFFER_BYTES; i++) send_rx(i[7:0] ^ 8'hA5 ^ 8'h5A);
        send_rx(first_end_r);
    endtask

    task automatic test_config();
        write_reg(CFG_UNUSED, 8'h77);
        send_packet(2, 1'b0);
        set_framing(8'h00, 8'hFF, 8'h00);
        send_packet(3, 1'b0);
        send_raw(1'b1, 8'h00, 1'b0);
        send_raw(1'b1, 8'hFF, 1'b0);
        send_raw(1'b1, 8'h00, 1'b0);
        set_framing(8'hFF, 8'h00, 8'hFF);
        send_packet(3, 1'b0);
        set_framing(8'h7E, 8'h7E, 8'h81);            // start and end share a code
        send_packet(2, 1'b0);
        set_framing(START_BYTE_RST, FIRST_END_BYTE_RST, SECOND_END_BYTE_RST);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 300;
        send_packet(8, 1'b0);
        wait_drained();
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int n);
        int r;
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        ovr_pct        = 2;
        stop_at        = items_sent + n;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70)
                send_packet(($urandom_range(9) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(1, 6), 1'b0);
            else if (r < 82)
                send_raw(1'($urandom_range(1)), 8'($urandom), $urandom_range(9) == 0);
            else if (r < 90)
                send_packet(0, 1'($urandom_range(1)));
            else
                send_packet($urandom_range(1, 6), 1'b1);
        end
        ovr_pct = 0;
    endtask

    task automatic test_random();
        run_random(0, 0, 8);
        set_framing(8'h00, 8'hFF, 8'h00);
        run_random(54, 0, 8);
        set_framing(8'hFF, 8'h00, 8'hFF);
        run_random(0, 54, 8);
        set_framing(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(23, 23, 8);
        wait_drained();
    endtask

    initial begin
        do_reset();
        test_directed();
        test_max_and_overflow();
        test_config();
        test_backpressure();
        test_random();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_outputs.size() != 0) begin
            errors++;
            $display("%0t: items pending expected 0 actual %0d", $time,
                     due_outputs.size());
        end
        if (errors == 0)
            $display("delimited_packet_deframer_top regression: pass");
        else
            $display("delimited_packet_deframer_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/dpd_pkg.sv
hdl/dpd_ram.sv
hdl/delimited_packet_deframer_top.sv
test/tb_delimited_packet_deframer_top.sv
